// ===== rtl/tire_sticky_friction_timer_assert.svh =====
// Assertion macros for the sticky friction timer checks.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef TIRE_STICKY_FRICTION_TIMER_ASSERT_SVH
`define TIRE_STICKY_FRICTION_TIMER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSFT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsft check failed");

// The consequent must hold in the cycle after the antecedent.
`define TSFT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsft check failed");

`endif

// ===== rtl/tsft_pkg.sv =====
package tsft_pkg;

    localparam int NUM_WHEELS = 4;
    localparam int FLAG_W     = 4;

    localparam logic [FLAG_W-1:0] WHEEL_MASK =
        (NUM_WHEELS >= FLAG_W) ? {FLAG_W{1'b1}} : FLAG_W'((1 << NUM_WHEELS) - 1);

    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USED_W = 66;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [15:0] WHEEL_RADIUS_RST    = 16'd6554;
    localparam logic [14:0] LNG_SPEED_LIMIT_RST = 15'd38;
    localparam logic [31:0] LNG_TIME_LIMIT_RST  = 32'd1000000;
    localparam logic [14:0] LAT_SPEED_LIMIT_RST = 15'd38;
    localparam logic [31:0] LAT_TIME_LIMIT_RST  = 32'd1000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WHEEL_RADIUS    = 3'd0,
        REG_LNG_SPEED_LIMIT = 3'd1,
        REG_LNG_TIME_LIMIT  = 3'd2,
        REG_LAT_SPEED_LIMIT = 3'd3,
        REG_LAT_TIME_LIMIT  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] wheel_radius;
        logic [14:0] lng_speed_limit;
        logic [31:0] lng_time_limit;
        logic [14:0] lat_speed_limit;
        logic [31:0] lat_time_limit;
    } cfg_t;

    typedef struct packed {
        logic [15:0]        tire_load;
        logic [15:0]        tire_friction;
        logic signed [15:0] long_speed;
        logic signed [15:0] lat_speed;
        logic signed [15:0] wheel_omega;
        logic [FLAG_W-1:0]  drive_flags;
        logic [FLAG_W-1:0]  brake_flags;
        logic [15:0]        time_step;
    } in_item_t;

    typedef struct packed {
        logic        lng_sticky;
        logic        lat_sticky;
        logic [31:0] lng_time_out;
        logic [31:0] lat_time_out;
    } res_t;

endpackage

// ===== rtl/tsft_cfg_regs.sv =====
module tsft_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [tsft_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tsft_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output tsft_pkg::cfg_t                   cfg
);

    tsft_pkg::cfg_t cfg_reg;
    tsft_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                tsft_pkg::REG_WHEEL_RADIUS:    cfg_next.wheel_radius    = cfg_wdata[15:0];
                tsft_pkg::REG_LNG_SPEED_LIMIT: cfg_next.lng_speed_limit = cfg_wdata[14:0];
                tsft_pkg::REG_LNG_TIME_LIMIT:  cfg_next.lng_time_limit  = cfg_wdata;
                tsft_pkg::REG_LAT_SPEED_LIMIT: cfg_next.lat_speed_limit = cfg_wdata[14:0];
                tsft_pkg::REG_LAT_TIME_LIMIT:  cfg_next.lat_time_limit  = cfg_wdata;
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wheel_radius    <= tsft_pkg::WHEEL_RADIUS_RST;
            cfg_reg.lng_speed_limit <= tsft_pkg::LNG_SPEED_LIMIT_RST;
            cfg_reg.lng_time_limit  <= tsft_pkg::LNG_TIME_LIMIT_RST;
            cfg_reg.lat_speed_limit <= tsft_pkg::LAT_SPEED_LIMIT_RST;
            cfg_reg.lat_time_limit  <= tsft_pkg::LAT_TIME_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/tsft_update.sv =====
module tsft_update
(
    input  tsft_pkg::in_item_t item,
    input  tsft_pkg::cfg_t     cfg,
    input  logic [31:0]        lng_time,
    input  logic [31:0]        lat_time,
    output tsft_pkg::res_t     res
);

    function automatic logic [16:0] mag16(input logic [15:0] v);
        logic [16:0] r;
        if (v[15])
        begin
            r = 17'h10000 - {1'b0, v};
        end
        else
        begin
            r = {1'b0, v};
        end
        return r;
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {17'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    logic        has_force;
    logic [16:0] lng_mag;
    logic [16:0] lat_mag;
    logic [16:0] omega_mag;
    logic [32:0] rim_speed;
    logic [32:0] rim_limit;
    logic        accel;
    logic        brake;
    logic        lng_slow;
    logic        rim_slow;
    logic        lat_slow;
    logic [31:0] lng_new;
    logic [31:0] lat_new;

    always_comb
    begin
        has_force = (item.tire_load != 16'd0) && (item.tire_friction != 16'd0);
        lng_mag   = mag16(item.long_speed);
        lat_mag   = mag16(item.lat_speed);
        omega_mag = mag16(item.wheel_omega);
        rim_speed = {16'b0, omega_mag} * {17'b0, cfg.wheel_radius};
        rim_limit = {4'b0, cfg.lng_speed_limit, 14'b0};
        accel     = (item.drive_flags & tsft_pkg::WHEEL_MASK) != '0;
        brake     = (item.brake_flags & tsft_pkg::WHEEL_MASK) != '0;
        lng_slow  = lng_mag < {2'b0, cfg.lng_speed_limit};
        rim_slow  = rim_speed < rim_limit;
        lat_slow  = lat_mag < {2'b0, cfg.lat_speed_limit};

        lng_new = (has_force && lng_slow && rim_slow && !accel) ?
                  sat_add(lng_time, item.time_step) : 32'd0;
        lat_new = (has_force && lat_slow && !accel) ?
                  sat_add(lat_time, item.time_step) : 32'd0;

        res.lng_time_out = lng_new;
        res.lat_time_out = lat_new;
        res.lng_sticky   = has_force &&
                           ((lng_slow && (item.wheel_omega == 16'sd0) && brake) ||
                            (lng_new > cfg.lng_time_limit));
        res.lat_sticky   = has_force && (lng_new != 32'd0) &&
                           (lat_new > cfg.lat_time_limit);
    end

endmodule

// ===== rtl/tire_sticky_friction_timer.sv =====
// A result is computed from the item in the input register and registered in the output register.
// Throughput: one item per cycle while m_tready is not held low; the timer update is combinational.
// An input register and an output register part the two stream sides.
// Reset (rst_n low, asynchronous) clears both timers, empties both stages
// and loads the configuration registers with their default values.
module tire_sticky_friction_timer
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [tsft_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tsft_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Fields from bit 0: tire_load, tire_friction, long_speed, lat_speed,
    // wheel_omega, drive_flags, brake_flags, time_step.
    input  logic [tsft_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // Fields from bit 0: lng_sticky, lat_sticky, lng_time_out, lat_time_out,
    // then zero padding.
    output logic [tsft_pkg::OUT_DATA_W-1:0]   m_tdata
);

    tsft_pkg::cfg_t     cfg;
    tsft_pkg::in_item_t in_item;
    tsft_pkg::in_item_t item_reg;
    tsft_pkg::res_t     res;
    tsft_pkg::res_t     res_reg;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] lng_time_reg;
    logic [31:0] lng_time_next;
    logic [31:0] lat_time_reg;
    logic [31:0] lat_time_next;
    logic        fire;
    logic        in_take;

    tsft_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tsft_update u_update
    (
        .item     (item_reg),
        .cfg      (cfg),
        .lng_time (lng_time_reg),
        .lat_time (lat_time_reg),
        .res      (res)
    );

    assign in_item.tire_load     = s_tdata[15:0];
    assign in_item.tire_friction = s_tdata[31:16];
    assign in_item.long_speed    = s_tdata[47:32];
    assign in_item.lat_speed     = s_tdata[63:48];
    assign in_item.wheel_omega   = s_tdata[79:64];
    assign in_item.drive_flags   = s_tdata[83:80];
    assign in_item.brake_flags   = s_tdata[87:84];
    assign in_item.time_step     = s_tdata[103:88];

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign in_take  = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next  = in_take ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
        out_valid_next = fire ? 1'b1 : ((m_tready) ? 1'b0 : out_valid_reg);
        lng_time_next  = fire ? res.lng_time_out : lng_time_reg;
        lat_time_next  = fire ? res.lat_time_out : lat_time_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            lng_time_reg  <= 32'd0;
            lat_time_reg  <= 32'd0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            lng_time_reg  <= lng_time_next;
            lat_time_reg  <= lat_time_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= in_item;
        end
        if (fire)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(tsft_pkg::OUT_DATA_W - tsft_pkg::OUT_USED_W){1'b0}},
                       res_reg.lat_time_out, res_reg.lng_time_out,
                       res_reg.lat_sticky, res_reg.lng_sticky};

endmodule

// ===== rtl/tsft_checker.sv =====
`include "tire_sticky_friction_timer_assert.svh"

module tsft_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [tsft_pkg::OUT_DATA_W-1:0]   m_tdata
);

    `TSFT_ASSERT_NEXT(a_out_holds, m_tvalid && !m_tready, m_tvalid)
    `TSFT_ASSERT_SAME(a_ready_when_empty, !m_tvalid, s_tready)
    `TSFT_ASSERT_SAME(a_lat_needs_lng, m_tvalid && m_tdata[1], m_tdata[33:2] != 32'd0)
    `TSFT_ASSERT_SAME(a_lat_needs_time, m_tvalid && m_tdata[1], m_tdata[65:34] != 32'd0)
    `TSFT_ASSERT_SAME(a_pad_zero, m_tvalid, m_tdata[71:66] == 6'd0)

endmodule

bind tire_sticky_friction_timer tsft_checker u_tsft_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    import tsft_pkg::*;

    localparam int FIRST_SPARE_REG = 5;
    localparam int HOLD_CYCLES     = 200;
    localparam int DRAIN_CYCLES    = 20000;
    localparam int MAX_REPORTS     = 40;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    res_t expected_results[$];
    int   mismatch_count  = 0;
    int   items_sent      = 0;
    int   results_checked = 0;
    int   reg_writes      = 0;
    bit   steady          = 1'b0;
    int   hold_requests   = 0;
    int   hold_served     = 0;

    logic [15:0] radius_q14    = WHEEL_RADIUS_RST;
    logic [14:0] lng_speed_lim = LNG_SPEED_LIMIT_RST;
    logic [31:0] lng_time_lim  = LNG_TIME_LIMIT_RST;
    logic [14:0] lat_speed_lim = LAT_SPEED_LIMIT_RST;
    logic [31:0] lat_time_lim  = LAT_TIME_LIMIT_RST;
    logic [31:0] lng_low_us    = '0;
    logic [31:0] lat_low_us    = '0;

    tire_sticky_friction_timer uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [15:0] magnitude(input logic [15:0] v);
        return v[15] ? (~v + 16'd1) : v;
    endfunction

    function automatic logic [31:0] add_saturating(input logic [31:0] a, input logic [15:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {17'd0, b};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    function automatic res_t predict_sticky(input in_item_t t);
        res_t        r;
        logic [15:0] lng_mag;
        logic [15:0] lat_mag;
        logic [15:0] omega_mag;
        logic [31:0] rim;
        logic [31:0] rim_limit;
        logic        driven;
        logic        braked;
        logic        lng_slow;
        logic        lng_running;
        r = '0;
        if (t.tire_load == 16'd0 || t.tire_friction == 16'd0)
        begin
            lng_low_us = '0;
            lat_low_us = '0;
        end
        else
        begin
            lng_mag   = magnitude(t.long_speed);
            lat_mag   = magnitude(t.lat_speed);
            omega_mag = magnitude(t.wheel_omega);
            rim       = 32'(omega_mag) * 32'(radius_q14);
            rim_limit = {3'd0, lng_speed_lim, 14'd0};
            driven    = |(t.drive_flags & WHEEL_MASK);
            braked    = |(t.brake_flags & WHEEL_MASK);
            lng_slow  = lng_mag < {1'b0, lng_speed_lim};
            if (lng_slow && rim < rim_limit && !driven)
                lng_low_us = add_saturating(lng_low_us, t.time_step);
            else
                lng_low_us = '0;
            lng_running = lng_low_us != 32'd0;
            r.lng_sticky = (lng_slow && t.wheel_omega == 16'd0 && braked) ||
                           (lng_low_us > lng_time_lim);
            if (lat_mag < {1'b0, lat_speed_lim} && !driven)
                lat_low_us = add_saturating(lat_low_us, t.time_step);
            else
                lat_low_us = '0;
            r.lat_sticky = lng_running && (lat_low_us > lat_time_lim);
        end
        r.lng_time_out = lng_low_us;
        r.lat_time_out = lat_low_us;
        return r;
    endfunction

    function automatic in_item_t make_tick(input logic [15:0] load, input logic [15:0] fric,
                                           input logic [15:0] lng, input logic [15:0] lat,
                                           input logic [15:0] omega, input logic [3:0] drive,
                                           input logic [3:0] brake, input logic [15:0] dt);
        in_item_t t;
        t.tire_load     = load;
        t.tire_friction = fric;
        t.long_speed    = lng;
        t.lat_speed     = lat;
        t.wheel_omega   = omega;
        t.drive_flags   = drive;
        t.brake_flags   = brake;
        t.time_step     = dt;
        return t;
    endfunction

    function automatic logic [15:0] near_limit(input int lim);
        int span;
        span = (lim + 2 > 32767) ? 32767 : lim + 2;
        return 16'(int'($urandom_range(2 * span)) - span);
    endfunction

    function automatic in_item_t random_tick();
        in_item_t t;
        int       kind;
        int       pick;
        longint   omega_span;
        kind = $urandom_range(99);
        if (kind < 80)
        begin
            if (radius_q14 == 16'd0)
                omega_span = 32767;
            else
                omega_span = (longint'(lng_speed_lim) << 14) / longint'(radius_q14);
            if (omega_span > 32767)
                omega_span = 32767;
            t.tire_load     = 16'($urandom_range(65535, 1));
            t.tire_friction = 16'($urandom_range(65535, 1));
            t.long_speed    = near_limit(int'(lng_speed_lim));
            t.lat_speed     = near_limit(int'(lat_speed_lim));
            t.wheel_omega   = ($urandom_range(3) == 0) ? 16'd0 : near_limit(int'(omega_span));
            t.drive_flags   = ($urandom_range(9) == 0) ? 4'($urandom) : 4'd0;
        end
        else
        begin
            t.tire_load     = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom);
            t.tire_friction = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom);
            t.long_speed    = 16'($urandom);
            t.lat_speed     = 16'($urandom);
            t.wheel_omega   = 16'($urandom);
            t.drive_flags   = 4'($urandom);
        end
        t.brake_flags = 4'($urandom);
        pick = $urandom_range(99);
        if (pick < 10)
            t.time_step = 16'd0;
        else if (pick < 20)
            t.time_step = 16'hFFFF;
        else
            t.time_step = 16'($urandom);
        return t;
    endfunction

    task automatic send_item(input in_item_t t);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 14)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {t.time_step, t.brake_flags, t.drive_flags, t.wheel_omega,
                     t.lat_speed, t.long_speed, t.tire_friction, t.tire_load};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_results.push_back(predict_sticky(t));
        items_sent++;
    endtask

    task automatic wait_for_results();
        int n;
        @(negedge clk);
        s_tvalid <= 1'b0;
        for (n = 0; n < DRAIN_CYCLES && expected_results.size() != 0; n++)
            @(posedge clk);
        if (expected_results.size() != 0)
        begin
            mismatch_count++;
            $error("%0d expected results never arrived", expected_results.size());
            expected_results.delete();
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_WHEEL_RADIUS:    radius_q14    = val[15:0];
            REG_LNG_SPEED_LIMIT: lng_speed_lim = val[14:0];
            REG_LNG_TIME_LIMIT:  lng_time_lim  = val;
            REG_LAT_SPEED_LIMIT: lat_speed_lim = val[14:0];
            REG_LAT_TIME_LIMIT:  lat_time_lim  = val;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic apply_settings(input logic [31:0] radius, input logic [31:0] lng_speed,
                                  input logic [31:0] lng_time, input logic [31:0] lat_speed,
                                  input logic [31:0] lat_time);
        write_reg(REG_WHEEL_RADIUS, radius);
        write_reg(REG_LNG_SPEED_LIMIT, lng_speed);
        write_reg(REG_LNG_TIME_LIMIT, lng_time);
        write_reg(REG_LAT_SPEED_LIMIT, lat_speed);
        write_reg(REG_LAT_TIME_LIMIT, lat_time);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] seen);
        if (want !== seen)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $error("%s: expected %0d, got %0d", name, want, seen);
        end
    endtask

    always @(posedge clk)
    begin
        res_t seen;
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.lng_sticky   = m_tdata[0];
            seen.lat_sticky   = m_tdata[1];
            seen.lng_time_out = m_tdata[33:2];
            seen.lat_time_out = m_tdata[65:34];
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $error("result item with no input item pending");
            end
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                compare_field("lng_sticky", 32'(want.lng_sticky), 32'(seen.lng_sticky));
                compare_field("lat_sticky", 32'(want.lat_sticky), 32'(seen.lat_sticky));
                compare_field("lng_time_out", want.lng_time_out, seen.lng_time_out);
                compare_field("lat_time_out", want.lat_time_out, seen.lat_time_out);
            end
        end
    end

    initial
    begin
        int held;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                m_tready <= 1'b0;
                for (held = 1; held < HOLD_CYCLES; held++)
                    @(negedge clk);
            end
            else
                m_tready <= steady || ($urandom_range(99) >= 14);
        end
    end

    task automatic test_directed();
        int k;
        // Default limits: no-force ticks, extremes and the locked, braked wheel.
        send_item(make_tick(16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 4'h0, 4'hF, 16'd1000));
        send_item(make_tick(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 4'h0, 4'hF, 16'd1000));
        send_item(make_tick(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 4'h0, 4'hF,
                            16'hFFFF));
        send_item(make_tick(16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 4'h0, 4'h1, 16'd0));
        send_item(make_tick(16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 4'h0, 4'h0, 16'd50));
        send_item(make_tick(16'd9, 16'd9, 16'h8000, 16'h8000, 16'h8000, 4'h0, 4'h0, 16'd100));
        wait_for_results();
        write_reg(REG_LNG_TIME_LIMIT, 32'd100);
        write_reg(REG_LAT_TIME_LIMIT, 32'd100);
        // Writes to indexes past the last register must change nothing.
        for (k = FIRST_SPARE_REG; k < 2 ** CFG_IDX_W; k++)
            write_reg(CFG_IDX_W'(k), 32'hFFFF_FFFF);
        send_item(make_tick(16'd7, 16'd7, 16'd5, 16'hFFFB, 16'd1, 4'h0, 4'h0, 16'd60));
        send_item(make_tick(16'd7, 16'd7, 16'd5, 16'hFFFB, 16'd1, 4'h0, 4'h0, 16'd60));
        for (k = 0; k < 4; k++)
        begin
            send_item(make_tick(16'd7, 16'd7, 16'd0, 16'd0, 16'd0, 4'(1 << k), 4'h0, 16'd60));
            send_item(make_tick(16'd7, 16'd7, 16'd0, 16'd0, 16'd0, 4'h0, 4'h0, 16'd60));
        end
        send_item(make_tick(16'd100, 16'd100, 16'd37, 16'd0, 16'd0, 4'h0, 4'h8, 16'd0));
        send_item(make_tick(16'd100, 16'd100, 16'd38, 16'd0, 16'd0, 4'h0, 4'h8, 16'd10));
        send_item(make_tick(16'd100, 16'd100, 16'hFFDB, 16'd37, 16'd95, 4'h0, 4'h0, 16'd10));
        send_item(make_tick(16'd100, 16'd100, 16'd0, 16'd38, 16'hFFA2, 4'h0, 4'h0, 16'd10));
        send_item(make_tick(16'd100, 16'd100, 16'd0, 16'hFFDA, 16'd0, 4'h0, 4'h0, 16'd200));
        send_item(make_tick(16'd100, 16'd100, 16'd0, 16'hFFDB, 16'd0, 4'h0, 4'h0, 16'd200));
        wait_for_results();
    endtask

    task automatic run_random_items(input int count);
        int n;
        for (n = 0; n < count; n++)
            send_item(random_tick());
        wait_for_results();
    endtask

    task automatic test_random_settings();
        apply_settings(32'd6554, 32'd38, 32'd200000, 32'd38, 32'd150000);
        run_random_items(70);
        apply_settings(32'd0, 32'd32767, 32'd0, 32'd32767, 32'd0);
        run_random_items(70);
        steady = 1'b1;
        apply_settings(32'd65535, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        run_random_items(70);
        steady = 1'b0;
        apply_settings($urandom_range(65535), $urandom_range(32767), $urandom_range(300000),
                       $urandom_range(32767), $urandom);
        run_random_items(70);
        apply_settings(32'd16384, 32'd256, 32'd50000, 32'd512, 32'd80000);
        hold_requests++;
        run_random_items(70);
    endtask

    task automatic test_long_timers();
        int n;
        // 65535 us per tick: both timers climb past large limits in a few dozen ticks.
        apply_settings(32'd1, 32'd32767, 32'd2000000, 32'd32767, 32'd1500000);
        steady = 1'b1;
        for (n = 0; n < 40; n++)
            send_item(make_tick(16'd1000, 16'd4096, 16'd0, 16'd0, 16'd0, 4'h0, 4'h0, 16'hFFFF));
        wait_for_results();
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_settings();
        test_long_timers();
        wait_for_results();
        repeat (8) @(posedge clk);
        $display("Checked %0d results from %0d items across %0d register writes.",
                 results_checked, items_sent, reg_writes);
        $display("Run covered no-force ticks, drive and brake bits, speed edges and limits.");
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
